// ===== hdl/sgm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared types, constants and elaboration-time trig tables for the Sobel
// gradient, magnitude and direction unit.
// ----------------------------------------------------------------------------
package sgm_pkg;

    // window layout in the input stream, lowest field first
    localparam int NUM_PIX = 8;
    localparam int PIX_TL  = 0;
    localparam int PIX_TM  = 1;
    localparam int PIX_TR  = 2;
    localparam int PIX_ML  = 3;
    localparam int PIX_MR  = 4;
    localparam int PIX_BL  = 5;
    localparam int PIX_BM  = 6;
    localparam int PIX_BR  = 7;

    // result field widths
    localparam int GRAD_W      = 11;
    localparam int MAG_W       = 11;
    localparam int DIR_W       = 9;
    localparam int DEG_W       = 8;
    localparam int OUT_PAD_W   = 6;
    localparam int OUT_TDATA_W = 48;

    localparam logic signed [GRAD_W-1:0] GRAD_MAX = 11'sd1023;
    localparam logic signed [GRAD_W-1:0] GRAD_MIN = -11'sd1024;
    localparam logic [MAG_W-1:0]         MAG_SAT  = 11'h7FF;
    localparam logic [DEG_W-1:0]         DEG_FLAT     = 8'd0;
    localparam logic [DEG_W-1:0]         DEG_RIGHT    = 8'd90;
    localparam logic [DEG_W-1:0]         DEG_STRAIGHT = 8'd180;

    // angle search: binary search over whole degrees 1..89
    localparam int ANG_IDX_W   = 7;
    localparam int ANG_LEVELS  = 7;
    localparam int ANG_LAT     = 2 * ANG_LEVELS;
    localparam int ANG_MAX_DEG = 89;
    localparam int RIGHT_ANGLE = 90;

    // trig table format: unsigned Q44, split into two halves for multiplies
    localparam int TRIG_W      = 44;
    localparam int TRIG_HALF_W = 22;

    localparam logic [63:0] PI_Q60          = 64'h3243F6A8885A308D;
    localparam logic [63:0] RAD_PER_DEG_Q60 = PI_Q60 / 64'd180;
    localparam int          SERIES_TERMS    = 14;
    localparam logic [63:0] ROUND_HALF      = 64'h8000;
    localparam int          ROUND_SHIFT     = 16;

    typedef logic [2**ANG_IDX_W-1:0][TRIG_W-1:0] trig_tab_t;

    // side information that travels beside the magnitude and angle pipes
    typedef struct packed {
        logic signed [GRAD_W-1:0] grad_x;
        logic signed [GRAD_W-1:0] grad_y;
        logic                     gx_pos;
        logic                     gy_neg;
        logic                     ax_zero;
        logic                     ay_zero;
        logic                     diag;
    } side_t;

    // result item as packed into tdata, grad_x in the lowest bits
    typedef struct packed {
        logic [OUT_PAD_W-1:0]     pad;
        logic signed [DIR_W-1:0]  direction_deg;
        logic [MAG_W-1:0]         magnitude;
        logic signed [GRAD_W-1:0] grad_y;
        logic signed [GRAD_W-1:0] grad_x;
    } out_t;

    // (a*b) >> 60, kept to 64 bits
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // sine of a whole number of degrees in Q60 from a Taylor series
    function automatic logic [63:0] sine_q60(input int unsigned deg);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x    = RAD_PER_DEG_Q60 * 64'(deg);
        x2   = mul_q60(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n <= SERIES_TERMS; n++) begin
            term = mul_q60(term, x2) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // sine or cosine table, rounded to Q44; unused entries stay zero
    function automatic trig_tab_t build_trig(input logic want_cos);
        trig_tab_t   tab;
        logic [63:0] s;
        tab = '0;
        for (int k = 1; k <= ANG_MAX_DEG; k++) begin
            if (want_cos) begin
                s = sine_q60(32'(RIGHT_ANGLE - k));
            end else begin
                s = sine_q60(32'(k));
            end
            s      = (s + ROUND_HALF) >> ROUND_SHIFT;
            tab[k] = s[TRIG_W-1:0];
        end
        return tab;
    endfunction

    localparam trig_tab_t SIN_TAB = build_trig(1'b0);
    localparam trig_tab_t COS_TAB = build_trig(1'b1);

endpackage
`default_nettype wire

// ===== hdl/sobel_gradient_magnitude_angle_unit.sv =====
`default_nettype none
// Throughput: one window per cycle; every stage advances together unless the output
// skid buffer is full, so a stall of m_tready backs up the pipe one transfer later.
// Pipe depth is set by the 7-level degree search (2 stages a level) or by the
// square root (one digit a stage), whichever is longer; the shorter path is delayed.
// Reset (aresetn low, synchronous) clears the valid bits and the output buffer.
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_angle_unit
// Sobel 3x3 gradients, floor-sqrt magnitude and truncated direction in
// degrees for one pixel window per transfer.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_angle_unit #(
    parameter int PIXEL_BITS = 8
) (
    input  wire logic                                         aclk,
    input  wire logic                                         aresetn,
    input  wire logic                                         s_tvalid,
    output logic                                              s_tready,
    // tl, tm, tr, ml, mr, bl, bm, br from the lowest bit up, PIXEL_BITS each
    input  wire logic [sgm_pkg::NUM_PIX*PIXEL_BITS-1:0]       s_tdata,
    output logic                                              m_tvalid,
    input  wire logic                                         m_tready,
    // grad_x[10:0], grad_y[21:11], magnitude[32:22], direction_deg[41:33], zero pad
    output logic [sgm_pkg::OUT_TDATA_W-1:0]                   m_tdata
);
    import sgm_pkg::*;

    localparam int GW      = PIXEL_BITS + 3;
    localparam int AW      = PIXEL_BITS + 2;
    localparam int RW      = AW + 1;
    localparam int MAG_LAT = 2 + RW;
    localparam int DLY     = (MAG_LAT > ANG_LAT) ? MAG_LAT : ANG_LAT;
    localparam int MAG_PAD = DLY - MAG_LAT;
    localparam int ANG_PAD = DLY - ANG_LAT;
    localparam int NST     = 3 + DLY;

    logic                  pipe_ce;
    logic [NST-1:0]        vld_reg;
    logic [PIXEL_BITS-1:0] pix [NUM_PIX];
    logic [GW-1:0]         pos_x, neg_x, pos_y, neg_y;
    logic signed [GW-1:0]  gx_reg, gy_reg;
    logic [AW-1:0]         ax_next, ay_next;
    logic [AW-1:0]         ax_reg, ay_reg;
    side_t                 side_next, side_reg;
    side_t                 side_dly_reg [DLY];
    logic [RW-1:0]         root_raw, root_al;
    logic [ANG_IDX_W-1:0]  fl_raw, fl_al;
    side_t                 side_fin;
    logic [DEG_W-1:0]      deg_abs;
    out_t                  fin_next, fin_reg;
    out_t                  out_data_reg, skid_data_reg;
    logic                  out_valid_reg, out_valid_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic                  take;

    // the whole pipe moves while the skid slot is free
    assign pipe_ce  = !skid_valid_reg;
    assign s_tready = pipe_ce;

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (pipe_ce) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // stage 1: gradients
    for (genvar p = 0; p < NUM_PIX; p++) begin : g_unpack
        assign pix[p] = s_tdata[p*PIXEL_BITS +: PIXEL_BITS];
    end

    always_comb begin
        pos_x = GW'(pix[PIX_TR]) + (GW'(pix[PIX_MR]) << 1) + GW'(pix[PIX_BR]);
        neg_x = GW'(pix[PIX_TL]) + (GW'(pix[PIX_ML]) << 1) + GW'(pix[PIX_BL]);
        pos_y = GW'(pix[PIX_BL]) + (GW'(pix[PIX_BM]) << 1) + GW'(pix[PIX_BR]);
        neg_y = GW'(pix[PIX_TL]) + (GW'(pix[PIX_TM]) << 1) + GW'(pix[PIX_TR]);
    end

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            gx_reg <= $signed(pos_x - neg_x);
            gy_reg <= $signed(pos_y - neg_y);
        end
    end

    // stage 2: absolute values, saturated gradients and angle case flags
    always_comb begin
        ax_next = AW'(gx_reg[GW-1] ? -gx_reg : gx_reg);
        ay_next = AW'(gy_reg[GW-1] ? -gy_reg : gy_reg);
        if (gx_reg > GRAD_MAX) begin
            side_next.grad_x = GRAD_MAX;
        end else if (gx_reg < GRAD_MIN) begin
            side_next.grad_x = GRAD_MIN;
        end else begin
            side_next.grad_x = GRAD_W'(gx_reg);
        end
        if (gy_reg > GRAD_MAX) begin
            side_next.grad_y = GRAD_MAX;
        end else if (gy_reg < GRAD_MIN) begin
            side_next.grad_y = GRAD_MIN;
        end else begin
            side_next.grad_y = GRAD_W'(gy_reg);
        end
        side_next.gx_pos  = !gx_reg[GW-1] && (ax_next != '0);
        side_next.gy_neg  = gy_reg[GW-1];
        side_next.ax_zero = (ax_next == '0);
        side_next.ay_zero = (ay_next == '0);
        side_next.diag    = (ax_next == ay_next);
    end

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            side_reg <= side_next;
        end
    end

    // magnitude and angle pipes
    sgm_isqrt #(
        .AW (AW)
    ) u_isqrt (
        .aclk (aclk),
        .ce   (pipe_ce),
        .ax   (ax_reg),
        .ay   (ay_reg),
        .root (root_raw)
    );

    sgm_angle #(
        .AW (AW)
    ) u_angle (
        .aclk      (aclk),
        .ce        (pipe_ce),
        .ax        (ax_reg),
        .ay        (ay_reg),
        .floor_deg (fl_raw)
    );

    // side information delay to match the longer pipe
    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            side_dly_reg[0] <= side_reg;
            for (int i = 1; i < DLY; i++) begin
                side_dly_reg[i] <= side_dly_reg[i-1];
            end
        end
    end

    if (MAG_PAD == 0) begin : g_mag_direct
        assign root_al = root_raw;
    end else begin : g_mag_pad
        logic [RW-1:0] mag_pad_reg [MAG_PAD];
        always_ff @(posedge aclk) begin
            if (pipe_ce) begin
                mag_pad_reg[0] <= root_raw;
                for (int i = 1; i < MAG_PAD; i++) begin
                    mag_pad_reg[i] <= mag_pad_reg[i-1];
                end
            end
        end
        assign root_al = mag_pad_reg[MAG_PAD-1];
    end

    if (ANG_PAD == 0) begin : g_ang_direct
        assign fl_al = fl_raw;
    end else begin : g_ang_pad
        logic [ANG_IDX_W-1:0] ang_pad_reg [ANG_PAD];
        always_ff @(posedge aclk) begin
            if (pipe_ce) begin
                ang_pad_reg[0] <= fl_raw;
                for (int i = 1; i < ANG_PAD; i++) begin
                    ang_pad_reg[i] <= ang_pad_reg[i-1];
                end
            end
        end
        assign fl_al = ang_pad_reg[ANG_PAD-1];
    end

    // final stage: quadrant fold, sign and magnitude clamp
    always_comb begin
        side_fin = side_dly_reg[DLY-1];
        if (side_fin.ax_zero && side_fin.ay_zero) begin
            deg_abs = DEG_FLAT;
        end else if (side_fin.ax_zero) begin
            deg_abs = DEG_RIGHT;
        end else if (side_fin.gx_pos) begin
            deg_abs = DEG_W'(fl_al);
        end else begin
            deg_abs = DEG_STRAIGHT - DEG_W'(fl_al)
                    - DEG_W'(!side_fin.ay_zero && !side_fin.diag);
        end
        fin_next.pad    = '0;
        fin_next.grad_x = side_fin.grad_x;
        fin_next.grad_y = side_fin.grad_y;
        if (side_fin.gy_neg) begin
            fin_next.direction_deg = DIR_W'(0) - {1'b0, deg_abs};
        end else begin
            fin_next.direction_deg = {1'b0, deg_abs};
        end
        if (32'(root_al) > 32'(MAG_SAT)) begin
            fin_next.magnitude = MAG_SAT;
        end else begin
            fin_next.magnitude = MAG_W'(root_al);
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            fin_reg <= fin_next;
        end
    end

    // output register plus one skid slot
    assign take = pipe_ce && vld_reg[NST-1];

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (take) begin
            if (out_valid_reg && !m_tready) begin
                skid_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b1;
            end
        end else if (out_valid_reg && m_tready) begin
            if (skid_valid_reg) begin
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            if (out_valid_reg && !m_tready) begin
                skid_data_reg <= fin_reg;
            end else begin
                out_data_reg <= fin_reg;
            end
        end else if (out_valid_reg && m_tready && skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds a result while the output register is empty");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_ce |=> $stable(vld_reg))
        else $error("pipe valid bits moved during a stall");

    a_flat_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_data_reg.magnitude == '0)) |->
        ((out_data_reg.grad_x == '0) && (out_data_reg.grad_y == '0)
         && (out_data_reg.direction_deg == '0)))
        else $error("zero magnitude with nonzero gradient or direction");

    a_dir_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((out_data_reg.direction_deg <= 180)
                      && (out_data_reg.direction_deg >= -180)))
        else $error("direction outside -180..180");

    // shallow angles below one degree truncate to zero
    a_dir_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (out_data_reg.grad_y < 0)) |-> (out_data_reg.direction_deg <= 0))
        else $error("negative vertical gradient with positive direction");

endmodule
`default_nettype wire

// ===== hdl/sgm_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sgm_isqrt
// Pipelined floor square root of ax*ax + ay*ay: one squaring stage, one
// sum stage, then one restoring root digit per stage.
// ----------------------------------------------------------------------------
module sgm_isqrt #(
    parameter int AW = 10
) (
    input  wire logic          aclk,
    input  wire logic          ce,
    input  wire logic [AW-1:0] ax,
    input  wire logic [AW-1:0] ay,
    output logic [AW:0]        root
);
    localparam int RW   = AW + 1;
    localparam int SQW  = 2 * AW;
    localparam int RADW = 2 * RW;
    localparam int REMW = RW + 3;

    logic [SQW-1:0]  sqx_reg;
    logic [SQW-1:0]  sqy_reg;
    logic [RADW-1:0] rad_reg;
    logic [REMW-1:0] rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [RADW-1:0] rads_reg [RW];

    // squares, then their sum
    always_ff @(posedge aclk) begin
        if (ce) begin
            sqx_reg <= ax * ax;
            sqy_reg <= ay * ay;
            rad_reg <= RADW'(sqx_reg) + RADW'(sqy_reg);
        end
    end

    // one root digit per stage, two radicand bits consumed each time
    for (genvar i = 0; i < RW; i++) begin : g_digit
        logic [REMW-1:0] in_rem;
        logic [RW-1:0]   in_root;
        logic [RADW-1:0] in_rad;
        logic [REMW-1:0] rem_sh;
        logic [REMW-1:0] trial;
        logic [REMW-1:0] rem_next;
        logic [RW-1:0]   root_next;

        if (i == 0) begin : g_first
            assign in_rem  = '0;
            assign in_root = '0;
            assign in_rad  = rad_reg;
        end else begin : g_chain
            assign in_rem  = rem_reg[i-1];
            assign in_root = root_reg[i-1];
            assign in_rad  = rads_reg[i-1];
        end

        always_comb begin
            rem_sh = {in_rem[REMW-3:0], in_rad[RADW-1:RADW-2]};
            trial  = REMW'({in_root, 2'b01});
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {in_root[RW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {in_root[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
                rads_reg[i] <= in_rad << 2;
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule
`default_nettype wire

// ===== hdl/sgm_angle.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sgm_angle
// Floor of atan(ay/ax) in whole degrees by a pipelined binary search over
// the Q44 sine and cosine tables; two stages per search level.
// ----------------------------------------------------------------------------
module sgm_angle #(
    parameter int AW = 10
) (
    input  wire logic                   aclk,
    input  wire logic                   ce,
    input  wire logic [AW-1:0]          ax,
    input  wire logic [AW-1:0]          ay,
    output logic [sgm_pkg::ANG_IDX_W-1:0] floor_deg
);
    import sgm_pkg::*;

    localparam int PHW = AW + TRIG_HALF_W;
    localparam int PW  = AW + TRIG_W;

    // first stage of a level: table lookup and partial products
    logic [AW-1:0]        a_ax_reg   [ANG_LEVELS];
    logic [AW-1:0]        a_ay_reg   [ANG_LEVELS];
    logic [ANG_IDX_W-1:0] a_cand_reg [ANG_LEVELS];
    logic [ANG_IDX_W-1:0] a_res_reg  [ANG_LEVELS];
    logic                 a_ok_reg   [ANG_LEVELS];
    logic [PHW-1:0]       py_hi_reg  [ANG_LEVELS];
    logic [PHW-1:0]       py_lo_reg  [ANG_LEVELS];
    logic [PHW-1:0]       px_hi_reg  [ANG_LEVELS];
    logic [PHW-1:0]       px_lo_reg  [ANG_LEVELS];
    // second stage of a level: full compare and search update
    logic [AW-1:0]        b_ax_reg   [ANG_LEVELS];
    logic [AW-1:0]        b_ay_reg   [ANG_LEVELS];
    logic [ANG_IDX_W-1:0] b_res_reg  [ANG_LEVELS];

    for (genvar j = 0; j < ANG_LEVELS; j++) begin : g_level
        logic [AW-1:0]        in_ax;
        logic [AW-1:0]        in_ay;
        logic [ANG_IDX_W-1:0] in_res;
        logic [ANG_IDX_W-1:0] cand;
        logic [TRIG_W-1:0]    cos_v;
        logic [TRIG_W-1:0]    sin_v;
        logic [PW-1:0]        yc;
        logic [PW-1:0]        xs;
        logic [ANG_IDX_W-1:0] res_next;

        if (j == 0) begin : g_first
            assign in_ax  = ax;
            assign in_ay  = ay;
            assign in_res = '0;
        end else begin : g_chain
            assign in_ax  = b_ax_reg[j-1];
            assign in_ay  = b_ay_reg[j-1];
            assign in_res = b_res_reg[j-1];
        end

        // try the next lower bit of the degree count
        always_comb begin
            cand = in_res;
            cand[ANG_LEVELS-1-j] = 1'b1;
            cos_v = COS_TAB[cand];
            sin_v = SIN_TAB[cand];
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                a_ax_reg[j]   <= in_ax;
                a_ay_reg[j]   <= in_ay;
                a_cand_reg[j] <= cand;
                a_res_reg[j]  <= in_res;
                a_ok_reg[j]   <= (32'(cand) <= ANG_MAX_DEG);
                py_hi_reg[j]  <= PHW'(in_ay) * PHW'(cos_v[TRIG_W-1:TRIG_HALF_W]);
                py_lo_reg[j]  <= PHW'(in_ay) * PHW'(cos_v[TRIG_HALF_W-1:0]);
                px_hi_reg[j]  <= PHW'(in_ax) * PHW'(sin_v[TRIG_W-1:TRIG_HALF_W]);
                px_lo_reg[j]  <= PHW'(in_ax) * PHW'(sin_v[TRIG_HALF_W-1:0]);
            end
        end

        // keep the candidate when it is at most 89 degrees and ay*cos(k) >= ax*sin(k)
        always_comb begin
            yc = PW'({py_hi_reg[j], {TRIG_HALF_W{1'b0}}}) + PW'(py_lo_reg[j]);
            xs = PW'({px_hi_reg[j], {TRIG_HALF_W{1'b0}}}) + PW'(px_lo_reg[j]);
            if (a_ok_reg[j] && (yc >= xs)) begin
                res_next = a_cand_reg[j];
            end else begin
                res_next = a_res_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                b_ax_reg[j]  <= a_ax_reg[j];
                b_ay_reg[j]  <= a_ay_reg[j];
                b_res_reg[j] <= res_next;
            end
        end
    end

    assign floor_deg = b_res_reg[ANG_LEVELS-1];

endmodule
`default_nettype wire

// ===== test/sobel_gradient_magnitude_angle_unit_check.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_angle_unit_check
// Watches both stream channels of the Sobel unit. For every window taken in,
// it works out grad_x, grad_y, the floor-sqrt magnitude and the truncated
// direction. It then checks each result transfer against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_angle_unit_check #(
    parameter int PIX_W = 8
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     s_tvalid,
    input  wire logic                                     s_tready,
    input  wire logic [sgm_pkg::NUM_PIX*PIX_W-1:0]        s_tdata,
    input  wire logic                                     m_tvalid,
    input  wire logic                                     m_tready,
    input  wire logic [sgm_pkg::OUT_TDATA_W-1:0]          m_tdata,
    output int                                            mismatch_count,
    output int                                            results_pending,
    output int                                            results_checked,
    output int                                            edge_windows
);
    import sgm_pkg::*;

    localparam int     REPORT_LIMIT = 30;
    localparam real    PI_REAL      = 3.14159265358979323846;
    localparam real    Q44_SCALE    = 17592186044416.0;

    longint sin_q44 [90];
    longint cos_q44 [90];
    out_t   pending_gradients [$];

    // sine and cosine of whole degrees in Q44; cosine mirrors the sine entries
    // so that the 45 degree entries are identical
    initial begin
        sin_q44[0] = 0;
        cos_q44[0] = 64'd1 << 44;
        for (int k = 1; k < 90; k++) begin
            sin_q44[k] = longint'($sin(real'(k) * PI_REAL / 180.0) * Q44_SCALE);
        end
        for (int k = 1; k < 90; k++) begin
            cos_q44[k] = sin_q44[90 - k];
        end
    end

    // gradients, magnitude and direction of one 3x3 window
    function automatic out_t sobel_result(input logic [NUM_PIX*PIX_W-1:0] win);
        int   px [NUM_PIX];
        int   gx;
        int   gy;
        int   ax;
        int   ay;
        int   sq;
        int   mag;
        int   deg;
        int   whole;
        out_t r;
        for (int i = 0; i < NUM_PIX; i++) begin
            px[i] = int'(win[i*PIX_W +: PIX_W]);
        end
        gx = (px[PIX_TR] + 2 * px[PIX_MR] + px[PIX_BR])
           - (px[PIX_TL] + 2 * px[PIX_ML] + px[PIX_BL]);
        gy = (px[PIX_BL] + 2 * px[PIX_BM] + px[PIX_BR])
           - (px[PIX_TL] + 2 * px[PIX_TM] + px[PIX_TR]);
        ax = (gx < 0) ? -gx : gx;
        ay = (gy < 0) ? -gy : gy;

        // integer square root, nudged onto the exact floor
        sq  = ax * ax + ay * ay;
        mag = int'($sqrt(real'(sq)));
        while (mag * mag > sq) begin
            mag--;
        end
        while ((mag + 1) * (mag + 1) <= sq) begin
            mag++;
        end

        // first-quadrant floor angle: count whole degrees with tan(k) <= ay/ax
        if (ax == 0 && ay == 0) begin
            deg = 0;
        end else if (ax == 0) begin
            deg = 90;
        end else begin
            whole = 0;
            for (int k = 1; k < 90; k++) begin
                if (longint'(ay) * cos_q44[k] >= longint'(ax) * sin_q44[k]) begin
                    whole++;
                end
            end
            if (gx > 0) begin
                deg = whole;
            end else if (ay == 0 || ay == ax) begin
                deg = 180 - whole;
            end else begin
                // off the exact angles the ceiling is one above the floor
                deg = 179 - whole;
            end
        end
        if (gy < 0) begin
            deg = -deg;
        end

        r               = '0;
        r.grad_x        = GRAD_W'(gx);
        r.grad_y        = GRAD_W'(gy);
        r.magnitude     = MAG_W'(mag);
        r.direction_deg = DIR_W'(deg);
        return r;
    endfunction

    // one line per mismatch; printing stops after REPORT_LIMIT mismatches, counting does not
    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_LIMIT) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // predict on every window transfer, compare on every result transfer
    always @(posedge aclk) begin
        out_t want;
        out_t got;
        if (!aresetn) begin
            pending_gradients.delete();
            mismatch_count  = 0;
            results_checked = 0;
            edge_windows    = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                want = sobel_result(s_tdata);
                if (want.grad_x == 0 || want.grad_y == 0 || want.grad_x == want.grad_y
                        || want.grad_x == -want.grad_y) begin
                    edge_windows++;
                end
                pending_gradients.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = out_t'(m_tdata);
                if (pending_gradients.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending, tdata %h",
                                              m_tdata));
                end else begin
                    want = pending_gradients.pop_front();
                    if (got.grad_x !== want.grad_x) begin
                        report_mismatch($sformatf("grad_x got %0d expected %0d",
                                                  got.grad_x, want.grad_x));
                    end
                    if (got.grad_y !== want.grad_y) begin
                        report_mismatch($sformatf("grad_y got %0d expected %0d",
                                                  got.grad_y, want.grad_y));
                    end
                    if (got.magnitude !== want.magnitude) begin
                        report_mismatch($sformatf("magnitude got %0d expected %0d",
                                                  got.magnitude, want.magnitude));
                    end
                    if (got.direction_deg !== want.direction_deg) begin
                        report_mismatch($sformatf("direction got %0d expected %0d",
                                                  got.direction_deg, want.direction_deg));
                    end
                    if (got.pad !== want.pad) begin
                        report_mismatch($sformatf("pad bits got %h", got.pad));
                    end
                    results_checked++;
                end
            end
        end
        results_pending <= pending_gradients.size();
    end

endmodule

// ===== test/sobel_gradient_magnitude_angle_unit_test.sv =====
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_angle_unit_test
// Drives 3x3 pixel windows into the Sobel unit: first a directed set of flat,
// axis-aligned, diagonal and single-pixel windows, then random windows that
// are uniform, nearly flat, or built from black and white pixels. The sender
// runs in random bursts and the receiver stalls in rotating patterns,
// including one long hold-off. A checker module predicts and compares.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude_angle_unit_test;
    import sgm_pkg::*;

    localparam int PIX_W          = 8;
    localparam int WIN_W          = NUM_PIX * PIX_W;
    localparam int RANDOM_WINDOWS = 1250;
    localparam int HOLD_AFTER     = 400;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MODE_CYCLES    = 50;

    typedef enum int {
        ALWAYS_READY,
        MOSTLY_READY,
        MOSTLY_STALLED,
        ALTERNATE
    } stall_mode_e;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [WIN_W-1:0]       s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int mismatch_count;
    int results_pending;
    int results_checked;
    int edge_windows;
    int windows_sent = 0;
    int burst_left   = 0;

    sobel_gradient_magnitude_angle_unit #(
        .PIXEL_BITS (PIX_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sobel_gradient_magnitude_angle_unit_check #(
        .PIX_W (PIX_W)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending),
        .results_checked (results_checked),
        .edge_windows    (edge_windows)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // run limit
    initial begin
        #400000;
        $display("[sobel_gradient_magnitude_angle_unit] ERROR");
        $finish;
    end

    // pack the eight neighbours into the input word
    function automatic logic [WIN_W-1:0] window(
        input int tl, input int tm, input int tr, input int ml,
        input int mr, input int bl, input int bm, input int br
    );
        logic [WIN_W-1:0] w;
        w = '0;
        w[PIX_TL*PIX_W +: PIX_W] = PIX_W'(tl);
        w[PIX_TM*PIX_W +: PIX_W] = PIX_W'(tm);
        w[PIX_TR*PIX_W +: PIX_W] = PIX_W'(tr);
        w[PIX_ML*PIX_W +: PIX_W] = PIX_W'(ml);
        w[PIX_MR*PIX_W +: PIX_W] = PIX_W'(mr);
        w[PIX_BL*PIX_W +: PIX_W] = PIX_W'(bl);
        w[PIX_BM*PIX_W +: PIX_W] = PIX_W'(bm);
        w[PIX_BR*PIX_W +: PIX_W] = PIX_W'(br);
        return w;
    endfunction

    // offer one window until it transfers; a random gap closes each burst
    task automatic send_window(input logic [WIN_W-1:0] win);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= win;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        windows_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // receiver: rotating stall patterns plus one long hold-off
    initial begin
        int          cyc;
        bit          held;
        stall_mode_e mode;
        cyc  = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (!held && windows_sent >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                mode = stall_mode_e'((cyc / MODE_CYCLES) % 4);
                case (mode)
                    ALWAYS_READY:   m_tready <= 1'b1;
                    MOSTLY_READY:   m_tready <= ($urandom_range(0, 3) != 0);
                    MOSTLY_STALLED: m_tready <= ($urandom_range(0, 3) == 0);
                    default:        m_tready <= cyc[0];
                endcase
            end
        end
    end

    // stimulus and verdict
    initial begin
        int               kind;
        int               base;
        int               v;
        logic [WIN_W-1:0] win;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        burst_left = $urandom_range(1, 40);

        // flat windows
        send_window(window(0, 0, 0, 0, 0, 0, 0, 0));
        send_window(window(255, 255, 255, 255, 255, 255, 255, 255));
        // full-scale axis gradients: right, left, down, up
        send_window(window(0, 0, 255, 0, 255, 0, 0, 255));
        send_window(window(255, 0, 0, 255, 0, 255, 0, 0));
        send_window(window(0, 0, 0, 0, 0, 255, 255, 255));
        send_window(window(255, 255, 255, 0, 0, 0, 0, 0));
        // exact diagonals in all four quadrants
        send_window(window(0, 0, 255, 0, 255, 255, 255, 255));
        send_window(window(255, 255, 255, 255, 0, 255, 0, 0));
        send_window(window(255, 0, 0, 255, 0, 255, 255, 255));
        send_window(window(255, 255, 255, 0, 255, 0, 0, 255));
        // a single bright pixel at each position
        send_window(window(255, 0, 0, 0, 0, 0, 0, 0));
        send_window(window(0, 255, 0, 0, 0, 0, 0, 0));
        send_window(window(0, 0, 255, 0, 0, 0, 0, 0));
        send_window(window(0, 0, 0, 255, 0, 0, 0, 0));
        send_window(window(0, 0, 0, 0, 255, 0, 0, 0));
        send_window(window(0, 0, 0, 0, 0, 255, 0, 0));
        send_window(window(0, 0, 0, 0, 0, 0, 255, 0));
        send_window(window(0, 0, 0, 0, 0, 0, 0, 255));
        // smallest gradients and angles just off the axes
        send_window(window(0, 0, 1, 0, 0, 0, 0, 0));
        send_window(window(0, 0, 0, 1, 0, 0, 0, 0));
        send_window(window(0, 0, 0, 0, 0, 0, 1, 0));
        send_window(window(0, 0, 0, 0, 1, 0, 255, 0));
        send_window(window(0, 0, 0, 0, 255, 0, 1, 0));

        // random windows: uniform, nearly flat, or black and white only
        for (int n = 0; n < RANDOM_WINDOWS; n++) begin
            kind = $urandom_range(0, 3);
            if (kind <= 1) begin
                win = {$urandom, $urandom};
            end else if (kind == 2) begin
                base = $urandom_range(0, 255);
                for (int i = 0; i < NUM_PIX; i++) begin
                    v = base + $urandom_range(0, 6) - 3;
                    v = (v < 0) ? 0 : ((v > 255) ? 255 : v);
                    win[i*PIX_W +: PIX_W] = PIX_W'(v);
                end
            end else begin
                for (int i = 0; i < NUM_PIX; i++) begin
                    win[i*PIX_W +: PIX_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                end
            end
            send_window(win);
        end
        s_tvalid <= 1'b0;

        // let the pipe drain, then allow a few more cycles for strays
        @(posedge aclk);
        while (results_pending != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("windows sent: %0d, results checked: %0d, mismatches: %0d",
                 windows_sent, results_checked, mismatch_count);
        $display("flat, axis-aligned or exact-diagonal windows: %0d", edge_windows);
        if (mismatch_count == 0) begin
            $display("[sobel_gradient_magnitude_angle_unit] OK");
        end else begin
            $display("[sobel_gradient_magnitude_angle_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sgm_pkg.sv
hdl/sgm_isqrt.sv
hdl/sgm_angle.sv
hdl/sobel_gradient_magnitude_angle_unit.sv
test/sobel_gradient_magnitude_angle_unit_check.sv
test/sobel_gradient_magnitude_angle_unit_test.sv
